// File: hw/rtl/mfmt_pkg.sv
`timescale 1ns / 1ps

package mfmt_pkg;

  localparam int MOTOR_SLOTS_DEFAULT = 16;

  localparam int ID_W      = 11;
  localparam int ANGLE_W   = 16;
  localparam int COUNT_W   = 8;
  localparam int TOTAL_W   = 32;
  localparam int INDEX_W   = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [ID_W-1:0]    BASE_ID_RESET      = 11'd513;
  localparam logic [COUNT_W-1:0] CALIB_FRAMES_RESET = 8'd50;
  localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'hFF;

  // one mechanical turn of the encoder, and the jump that marks a wrap
  localparam logic signed [ANGLE_W:0] JUMP_LIMIT = 17'sd4096;
  localparam int TURN_SHIFT = 13;  // 8191 = (1 << 13) - 1

  typedef enum logic {
    OP_FEEDBACK = 1'b0,
    OP_REZERO   = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CFG_BASE_ID      = 1'b0,
    CFG_CALIB_FRAMES = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t                       operation;
    logic [ID_W-1:0]           frame_id;
    logic [ANGLE_W-1:0]        angle_word;
    logic signed [15:0]        speed_word;
    logic signed [15:0]        current_word;
    logic [7:0]                temp_byte;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        slot_index;
    logic                      unknown_id;
    logic                      calibrating;
    logic signed [15:0]        speed_out;
    logic signed [15:0]        current_out;
    logic [7:0]                temp_out;
    logic signed [TOTAL_W-1:0] total_angle_out;
  } out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] frame_count;
    logic [ANGLE_W-1:0] prev_angle;
    logic [ANGLE_W-1:0] zero_angle;
    logic [TOTAL_W-1:0] round_count;
    logic [TOTAL_W-1:0] accum_angle;
  } slot_state_t;

  typedef struct packed {
    logic [INDEX_W-1:0] slot_index;
    logic               unknown_id;
  } slot_sel_t;

endpackage

// File: hw/rtl/mfmt_ram.sv
`timescale 1ns / 1ps

module mfmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mfmt_decode.sv
`timescale 1ns / 1ps

module mfmt_decode #(
  parameter int MOTOR_SLOTS = mfmt_pkg::MOTOR_SLOTS_DEFAULT,
  localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1
) (
  input  logic [mfmt_pkg::ID_W-1:0] frame_id,
  input  logic [mfmt_pkg::ID_W-1:0] base_id,
  output logic [SLOT_W-1:0]         slot,
  output mfmt_pkg::slot_sel_t       sel
);

  import mfmt_pkg::*;

  logic [ID_W:0] diff;

  // borrow out of the subtract means the id sits below the base
  assign diff = {1'b0, frame_id} - {1'b0, base_id};

  assign slot           = diff[SLOT_W-1:0];
  assign sel.slot_index = diff[INDEX_W-1:0];
  assign sel.unknown_id = diff[ID_W] || (diff[ID_W-1:0] >= ID_W'(MOTOR_SLOTS));

endmodule

// File: hw/rtl/mfmt_update.sv
`timescale 1ns / 1ps

module mfmt_update (
  input  mfmt_pkg::in_t                item,
  input  mfmt_pkg::slot_sel_t          sel,
  input  logic [mfmt_pkg::COUNT_W-1:0] calib_frames,
  input  mfmt_pkg::slot_state_t        state,
  output mfmt_pkg::slot_state_t        state_next,
  output logic                         write,
  output mfmt_pkg::out_t               result
);

  import mfmt_pkg::*;

  logic                      calib;
  logic signed [ANGLE_W:0]   jump;
  logic [TOTAL_W-1:0]        rounds;
  logic [TOTAL_W-1:0]        total;

  assign calib = state.frame_count <= calib_frames;
  assign jump  = $signed({1'b0, item.angle_word}) - $signed({1'b0, state.prev_angle});

  always_comb begin
    if (jump > JUMP_LIMIT) begin
      rounds = state.round_count - 32'd1;
    end else if (jump < -JUMP_LIMIT) begin
      rounds = state.round_count + 32'd1;
    end else begin
      rounds = state.round_count;
    end
  end

  // rounds * 8191 as shift and subtract
  assign total = (rounds << TURN_SHIFT) - rounds
               + TOTAL_W'(item.angle_word) - TOTAL_W'(state.zero_angle);

  always_comb begin
    state_next = state;
    write      = 1'b0;
    result     = '0;
    if (sel.unknown_id) begin
      result.unknown_id = 1'b1;
    end else begin
      write             = 1'b1;
      result.slot_index = sel.slot_index;
      case (item.operation)
        OP_REZERO: begin
          state_next.zero_angle  = state.prev_angle;
          state_next.round_count = '0;
          result.total_angle_out = state.accum_angle;
        end
        default: begin
          if (calib) begin
            if (state.frame_count != COUNT_MAX) begin
              state_next.frame_count = state.frame_count + 8'd1;
            end
            state_next.prev_angle = item.angle_word;
            state_next.zero_angle = item.angle_word;
            result.calibrating    = 1'b1;
          end else begin
            state_next.round_count = rounds;
            state_next.prev_angle  = item.angle_word;
            state_next.accum_angle = total;
          end
          result.speed_out       = item.speed_word;
          result.current_out     = item.current_word;
          result.temp_out        = item.temp_byte;
          result.total_angle_out = state_next.accum_angle;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/motor_feedback_multiturn_tracker_unit.sv
`timescale 1ns / 1ps

// Port group  Handshake                  Payload
// in          in_valid / in_ready        in_item  (feedback frame or rezero)
// out         out_valid / out_ready      out_item (one per input beat)
// cfg         cfg_we                     cfg_index, cfg_data (no read-back)
//
// One beat per cycle sustained while out_ready is high. The slot record is
// read from the state RAM into s1; s1 updates it, writes it back and loads
// out_item; a one-entry bypass covers a write to the slot just read.
// rst clears config to defaults and marks every slot as zero, no sweep needed.
// out stalls hold the output register; in_ready drops only when it is full.

module motor_feedback_multiturn_tracker_unit #(
  parameter int MOTOR_SLOTS = mfmt_pkg::MOTOR_SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mfmt_pkg::in_t                  in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mfmt_pkg::out_t                 out_item,
  input  logic                           cfg_we,
  input  mfmt_pkg::cfg_index_t           cfg_index,
  input  logic [mfmt_pkg::CFG_DATA_W-1:0] cfg_data
);

  import mfmt_pkg::*;

  localparam int SLOT_W  = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
  localparam int STATE_W = $bits(slot_state_t);

  logic [ID_W-1:0]    base_id;
  logic [COUNT_W-1:0] calib_frames;

  logic [SLOT_W-1:0]  dec_slot;
  slot_sel_t          dec_sel;

  logic               s1_valid;
  in_t                s1_item;
  slot_sel_t          s1_sel;
  logic [SLOT_W-1:0]  s1_slot;
  logic               s1_hit;
  logic               s1_move;
  logic               in_fire;

  logic [MOTOR_SLOTS-1:0] slot_written;

  logic               fwd_valid;
  logic [SLOT_W-1:0]  fwd_slot;
  slot_state_t        fwd_state;

  slot_state_t        ram_rdata;
  slot_state_t        cur_state;
  slot_state_t        new_state;
  logic               upd_write;
  out_t               upd_result;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id      <= BASE_ID_RESET;
      calib_frames <= CALIB_FRAMES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_ID:      base_id      <= cfg_data[ID_W-1:0];
        CFG_CALIB_FRAMES: calib_frames <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  mfmt_decode #(
    .MOTOR_SLOTS(MOTOR_SLOTS)
  ) u_decode (
    .frame_id(in_item.frame_id),
    .base_id (base_id),
    .slot    (dec_slot),
    .sel     (dec_sel)
  );

  mfmt_ram #(
    .WIDTH(STATE_W),
    .DEPTH(MOTOR_SLOTS)
  ) u_state_ram (
    .clk  (clk),
    .we   (s1_move && upd_write),
    .waddr(s1_slot),
    .wdata(new_state),
    .re   (in_fire && !dec_sel.unknown_id),
    .raddr(dec_slot),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_item;
      s1_sel  <= dec_sel;
      s1_slot <= dec_slot;
      s1_hit  <= dec_sel.unknown_id ? 1'b0 : slot_written[dec_slot];
    end
  end

  // slots never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_written <= '0;
    end else if (s1_move && upd_write) begin
      slot_written[s1_slot] <= 1'b1;
    end
  end

  // the RAM read for the next beat lands on the same edge as this write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_move) begin
      fwd_valid <= upd_write;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      fwd_slot  <= s1_slot;
      fwd_state <= new_state;
    end
  end

  always_comb begin
    if (fwd_valid && fwd_slot == s1_slot) begin
      cur_state = fwd_state;
    end else if (s1_hit) begin
      cur_state = ram_rdata;
    end else begin
      cur_state = '0;
    end
  end

  mfmt_update u_update (
    .item        (s1_item),
    .sel         (s1_sel),
    .calib_frames(calib_frames),
    .state       (cur_state),
    .state_next  (new_state),
    .write       (upd_write),
    .result      (upd_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item <= upd_result;
    end
  end

endmodule

// File: dv/tb_motor_feedback_multiturn_tracker_unit.sv
`timescale 1ns / 1ps

module tb_motor_feedback_multiturn_tracker_unit;
  import mfmt_pkg::*;

  localparam int SLOTS        = MOTOR_SLOTS_DEFAULT;
  localparam int TURN_COUNTS  = 8191;
  localparam int WRAP_JUMP    = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED  = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_BASE_ID;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // tracker copy: config and per-slot records
  logic [ID_W-1:0] cfg_base = BASE_ID_RESET;
  logic [COUNT_W-1:0] cfg_calib = CALIB_FRAMES_RESET;
  logic [COUNT_W-1:0] slot_frames[SLOTS];
  logic [ANGLE_W-1:0] slot_last[SLOTS];
  logic [ANGLE_W-1:0] slot_offset[SLOTS];
  logic [TOTAL_W-1:0] slot_turns[SLOTS];
  logic [TOTAL_W-1:0] slot_total[SLOTS];

  in_t frame_q[$];
  out_t angle_results_q[$];
  out_t want_item;
  int walk_angle[SLOTS];
  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  motor_feedback_multiturn_tracker_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag_error(string msg);
    if (n_errors < MAX_PRINTED) begin
      $display("%0t ERROR %s", $time, msg);
    end
    n_errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s: got %h, want %h", name, got, want));
    end
  endtask

  // one frame or rezero through the slot records; returns the result beat
  function automatic out_t track_frame(in_t item);
    out_t res;
    int rel;
    int diff;
    res = '0;
    rel = int'(item.frame_id) - int'(cfg_base);
    if (rel < 0 || rel >= SLOTS) begin
      res.unknown_id = 1'b1;
    end else begin
      res.slot_index = rel[INDEX_W-1:0];
      if (item.operation == OP_REZERO) begin
        slot_offset[rel] = slot_last[rel];
        slot_turns[rel] = '0;
        res.total_angle_out = slot_total[rel];
      end else begin
        if (slot_frames[rel] <= cfg_calib) begin
          if (slot_frames[rel] != COUNT_MAX) begin
            slot_frames[rel] = slot_frames[rel] + 1'b1;
          end
          slot_last[rel] = item.angle_word;
          slot_offset[rel] = item.angle_word;
          res.calibrating = 1'b1;
        end else begin
          diff = int'(item.angle_word) - int'(slot_last[rel]);
          if (diff > WRAP_JUMP) begin
            slot_turns[rel] = slot_turns[rel] - 32'd1;
          end else if (diff < -WRAP_JUMP) begin
            slot_turns[rel] = slot_turns[rel] + 32'd1;
          end
          slot_last[rel] = item.angle_word;
          slot_total[rel] = slot_turns[rel] * 32'(TURN_COUNTS) + {16'b0, item.angle_word}
                            - {16'b0, slot_offset[rel]};
        end
        res.speed_out = item.speed_word;
        res.current_out = item.current_word;
        res.temp_out = item.temp_byte;
        res.total_angle_out = slot_total[rel];
      end
    end
    return res;
  endfunction

  // random frame: mostly well-aimed slots with walking angles, some stray ids
  function automatic in_t make_frame(int focus_pct);
    in_t f;
    int slot;
    int a;
    f.operation = ($urandom_range(99) < 6) ? OP_REZERO : OP_FEEDBACK;
    f.speed_word = 16'($urandom);
    f.current_word = 16'($urandom);
    f.temp_byte = 8'($urandom);
    if ($urandom_range(99) < 8) begin
      if (cfg_base > 0 && ($urandom_range(1) == 1 || int'(cfg_base) + SLOTS > 2047)) begin
        f.frame_id = ID_W'($urandom_range(int'(cfg_base) - 1));
      end else begin
        f.frame_id = ID_W'($urandom_range(2047, int'(cfg_base) + SLOTS));
      end
      f.angle_word = 16'($urandom);
    end else begin
      if ($urandom_range(99) < focus_pct) begin
        slot = 0;
      end else if ($urandom_range(1) == 1) begin
        slot = $urandom_range(3);
      end else begin
        slot = $urandom_range(SLOTS - 1);
      end
      if (int'(cfg_base) + slot > 2047) begin
        slot = 2047 - int'(cfg_base);
      end
      f.frame_id = ID_W'(int'(cfg_base) + slot);
      a = walk_angle[slot];
      case ($urandom_range(9))
        0: a = $urandom_range(65535);
        1: a = $urandom_range(TURN_COUNTS);
        // right at the wrap threshold, either side
        2: begin
          if ($urandom_range(1) == 1) begin
            a = (a + WRAP_JUMP + int'($urandom_range(1))) & 16'hFFFF;
          end else begin
            a = (a - WRAP_JUMP - int'($urandom_range(1))) & 16'hFFFF;
          end
        end
        // small steps on a 13-bit encoder, wrapping through zero
        default: a = (a + int'($urandom_range(1200)) - 600) & TURN_COUNTS;
      endcase
      walk_angle[slot] = a;
      f.angle_word = a[15:0];
    end
    return f;
  endfunction

  task automatic push_frame(in_t f);
    frame_q.push_back(f);
    n_queued++;
  endtask

  task automatic queue_frame(op_t op, int id, int ang, int spd, int cur, int tmp);
    in_t f;
    f.operation = op;
    f.frame_id = ID_W'(id);
    f.angle_word = 16'(ang);
    f.speed_word = 16'(spd);
    f.current_word = 16'(cur);
    f.temp_byte = 8'(tmp);
    push_frame(f);
  endtask

  task automatic write_reg(cfg_index_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_ID) begin
      cfg_base = ID_W'(val);
    end else begin
      cfg_calib = COUNT_W'(val);
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || angle_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int base, int calib, int send_pct, int recv_pct, int count,
                           int focus_pct);
    wait_idle();
    write_reg(CFG_BASE_ID, base);
    write_reg(CFG_CALIB_FRAMES, calib);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      push_frame(make_frame(focus_pct));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        angle_results_q.push_back(track_frame(in_item));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= frame_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (angle_results_q.size() == 0) begin
          flag_error("result beat with nothing outstanding");
        end else begin
          want_item = angle_results_q.pop_front();
          check_field("slot_index", out_item.slot_index, want_item.slot_index);
          check_field("unknown_id", out_item.unknown_id, want_item.unknown_id);
          check_field("calibrating", out_item.calibrating, want_item.calibrating);
          check_field("speed_out", out_item.speed_out, want_item.speed_out);
          check_field("current_out", out_item.current_out, want_item.current_out);
          check_field("temp_out", out_item.temp_out, want_item.temp_out);
          check_field("total_angle_out", out_item.total_angle_out,
                      want_item.total_angle_out);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_frames[s] = '0;
      slot_last[s] = '0;
      slot_offset[s] = '0;
      slot_turns[s] = '0;
      slot_total[s] = '0;
      walk_angle[s] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: ids around the slot window, both ops, the jump threshold
    write_reg(CFG_BASE_ID, 513);
    write_reg(CFG_CALIB_FRAMES, 1);
    queue_frame(OP_FEEDBACK, 0, 65535, -32768, 32767, 255);
    queue_frame(OP_FEEDBACK, 2047, 65535, 32767, -32768, 255);
    queue_frame(OP_FEEDBACK, 529, 1234, -1, -1, 1);
    queue_frame(OP_FEEDBACK, 528, 0, 32767, -32768, 255);
    queue_frame(OP_FEEDBACK, 513, 100, 5, -5, 30);
    queue_frame(OP_FEEDBACK, 513, 200, 6, -6, 31);
    queue_frame(OP_FEEDBACK, 513, 4296, 7, -7, 32);
    queue_frame(OP_FEEDBACK, 513, 8393, 8, -8, 33);
    queue_frame(OP_FEEDBACK, 513, 4297, 9, -9, 34);
    queue_frame(OP_FEEDBACK, 513, 200, 10, -10, 35);
    queue_frame(OP_FEEDBACK, 513, 65535, -32768, 32767, 0);
    queue_frame(OP_FEEDBACK, 513, 0, 32767, -32768, 255);
    queue_frame(OP_REZERO, 513, 777, 100, 200, 50);
    queue_frame(OP_FEEDBACK, 513, 10, 11, 12, 13);
    queue_frame(OP_REZERO, 528, 65535, -32768, -32768, 255);
    queue_frame(OP_REZERO, 512, 65535, 32767, 32767, 255);
    queue_frame(OP_FEEDBACK, 513, 8191, -100, 100, 77);
    queue_frame(OP_FEEDBACK, 514, 12345, 1000, -1000, 90);
    queue_frame(OP_FEEDBACK, 514, 12346, 0, 0, 0);

    run_phase(513, 0, 0, 0, 300, 0);
    run_phase(0, 1, 47, 0, 300, 0);
    run_phase(2032, 255, 0, 47, 300, 80);
    run_phase(2032, 254, 18, 18, 250, 50);
    run_phase(2047, 50, 0, 0, 150, 0);
    run_phase($urandom_range(2047), $urandom_range(7), 47, 0, 250, 0);
    run_phase(1000, 3, 0, 47, 200, 20);
    run_phase($urandom_range(2047), 0, 18, 18, 200, 0);

    wait_idle();
    if (n_errors == 0) begin
      $display("tb_motor_feedback_multiturn_tracker_unit: clean");
    end else begin
      $display("tb_motor_feedback_multiturn_tracker_unit: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_motor_feedback_multiturn_tracker_unit: errors");
    $finish;
  end

endmodule
